// ===== rtl/flow_message_counter_table_assert.svh =====
// assertion macros for the flow message counter table
`ifndef FLOW_MESSAGE_COUNTER_TABLE_ASSERT_SVH
`define FLOW_MESSAGE_COUNTER_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FMCT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fmct assertion failed");

// next-cycle implication, checked outside reset
`define FMCT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fmct assertion failed");

`endif

// ===== rtl/fmct_pkg.sv =====
// shared types and constants of the flow message counter table
`timescale 1ns / 1ps
`default_nettype none

package fmct_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 48;
   localparam int COUNT_W     = 32;
   localparam int GROUP_SIZE  = 32;
   localparam int GROUPS      = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_NEW     = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_REMOVED = 3'd3;
   localparam logic [2:0] ST_MISS    = 3'd4;

   localparam logic ACT_MESSAGE = 1'b0;
   localparam logic ACT_EXIT    = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] ip_addr;
      logic [15:0] src_port;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] msg_count;
   } rsp_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic               compare;
      logic               apply;
      logic               action;
      logic [KEY_W-1:0]   key;
      logic               found;
      logic [IDX_W-1:0]   hit_idx;
      logic [OCC_W-1:0]   occ;
      logic               full;
   } cell_ctl_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      sat_inc = (value == {COUNT_W{1'b1}}) ? value : value + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/fmct_cell.sv =====
// one table cell: key, count and local compare, takes its neighbor on removal
`timescale 1ns / 1ps
`default_nettype none

module fmct_cell
   import fmct_pkg::*;
(
   input  wire logic                 clock,
   input  wire cell_ctl_type         ctl,
   input  wire logic [IDX_W-1:0]     cell_idx,
   input  wire logic [KEY_W-1:0]     next_key,
   input  wire logic [COUNT_W-1:0]   next_count,
   output logic      [KEY_W-1:0]     key_out,
   output logic      [COUNT_W-1:0]   count_out,
   output logic                      hit
);

   logic [KEY_W-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               hit_ff, hit_in;
   logic [OCC_W-1:0]   idx_ext;
   logic               valid;
   logic               has_next;
   logic               behind_hit;

   assign idx_ext    = OCC_W'(cell_idx);
   assign valid      = idx_ext < ctl.occ;
   assign has_next   = OCC_W'(idx_ext + 1'b1) < ctl.occ;
   assign behind_hit = cell_idx >= ctl.hit_idx;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      hit_in   = hit_ff;
      if (ctl.compare) begin
         hit_in = valid && (key_ff == ctl.key);
      end
      if (ctl.apply) begin
         if (ctl.action == ACT_EXIT) begin
            // close the gap left by the removed entry
            if (ctl.found && behind_hit && has_next) begin
               key_in   = next_key;
               count_in = next_count;
            end
         end else begin
            if (ctl.found) begin
               if (hit_ff) begin
                  count_in = sat_inc(count_ff);
               end
            end else if (!ctl.full && (idx_ext == ctl.occ)) begin
               key_in   = ctl.key;
               count_in = COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
      hit_ff   <= hit_in;
   end

   assign key_out   = key_ff;
   assign count_out = count_ff;
   assign hit       = hit_ff;

endmodule

`default_nettype wire

// ===== rtl/fmct_gather.sv =====
// two-level registered reduction of cell hits into found flag, count and index
`timescale 1ns / 1ps
`default_nettype none

module fmct_gather
   import fmct_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [TABLE_DEPTH-1:0] hit_vec,
   input  wire logic [COUNT_W-1:0]   counts [TABLE_DEPTH],
   output logic                      found,
   output logic      [COUNT_W-1:0]   hit_count,
   output logic      [IDX_W-1:0]     hit_idx
);

   logic               grp_hit_ff   [GROUPS];
   logic [COUNT_W-1:0] grp_count_ff [GROUPS];
   logic [IDX_W-1:0]   grp_idx_ff   [GROUPS];
   logic               grp_hit_in   [GROUPS];
   logic [COUNT_W-1:0] grp_count_in [GROUPS];
   logic [IDX_W-1:0]   grp_idx_in   [GROUPS];

   logic               found_ff, found_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   // first level: one-hot and-or inside each group
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_hit_in[g]   = 1'b0;
         grp_count_in[g] = '0;
         grp_idx_in[g]   = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < TABLE_DEPTH) begin
               if (hit_vec[g * GROUP_SIZE + k]) begin
                  grp_hit_in[g]   = 1'b1;
                  grp_count_in[g] = grp_count_in[g] | counts[g * GROUP_SIZE + k];
                  grp_idx_in[g]   = grp_idx_in[g] | IDX_W'(g * GROUP_SIZE + k);
               end
            end
         end
      end
   end

   // second level: across groups
   always_comb begin
      found_in = 1'b0;
      count_in = '0;
      idx_in   = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (grp_hit_ff[g]) begin
            found_in = 1'b1;
            count_in = count_in | grp_count_ff[g];
            idx_in   = idx_in | grp_idx_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_hit_ff[g]   <= grp_hit_in[g];
         grp_count_ff[g] <= grp_count_in[g];
         grp_idx_ff[g]   <= grp_idx_in[g];
      end
      found_ff <= found_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
   end

   assign found     = found_ff;
   assign hit_count = count_ff;
   assign hit_idx   = idx_ff;

endmodule

`default_nettype wire

// ===== rtl/flow_message_counter_table.sv =====
// top level of the flow message counter table: sequencer, cell row and gather tree
// each item runs through compare, two gather stages and update; the result strobe
// is registered from update, and a new item may already be taken in update
// the gather tree over all cells sets this pace; busy is low in idle and update
// the receiver cannot stall; each result beat is shown for exactly one cycle
// reset clears occupancy and control, the table is empty at once with no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "flow_message_counter_table_assert.svh"

module flow_message_counter_table
   import fmct_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_RED1 = 3'd2;
   localparam logic [2:0] S_RED2 = 3'd3;
   localparam logic [2:0] S_ACT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic             rsp_strobe_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             accept;
   logic             full;

   cell_ctl_type       ctl;
   logic [KEY_W-1:0]   cell_key   [TABLE_DEPTH];
   logic [COUNT_W-1:0] cell_count [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] hit_vec;

   logic               found;
   logic [COUNT_W-1:0] hit_count;
   logic [IDX_W-1:0]   hit_idx;

   assign busy   = !((state_ff == S_IDLE) || (state_ff == S_ACT));
   assign accept = start && !busy;
   assign full   = occ_ff == OCC_W'(TABLE_DEPTH);

   always_comb begin
      ctl.compare = state_ff == S_CMP;
      ctl.apply   = state_ff == S_ACT;
      ctl.action  = req_ff.action;
      ctl.key     = {req_ff.ip_addr, req_ff.src_port};
      ctl.found   = found;
      ctl.hit_idx = hit_idx;
      ctl.occ     = occ_ff;
      ctl.full    = full;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0]   nk;
      logic [COUNT_W-1:0] nc;
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign nk = '0;
         assign nc = '0;
      end else begin : g_mid
         assign nk = cell_key[i + 1];
         assign nc = cell_count[i + 1];
      end
      fmct_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_idx   (IDX_W'(i)),
         .next_key   (nk),
         .next_count (nc),
         .key_out    (cell_key[i]),
         .count_out  (cell_count[i]),
         .hit        (hit_vec[i])
      );
   end

   fmct_gather u_gather (
      .clock     (clock),
      .hit_vec   (hit_vec),
      .counts    (cell_count),
      .found     (found),
      .hit_count (hit_count),
      .hit_idx   (hit_idx)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: state_in = accept ? S_CMP : S_IDLE;
         S_CMP:  state_in = S_RED1;
         S_RED1: state_in = S_RED2;
         S_RED2: state_in = S_ACT;
         S_ACT:  state_in = accept ? S_CMP : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      occ_in           = occ_ff;
      rsp_in.status    = ST_MISS;
      rsp_in.msg_count = '0;
      if (req_ff.action == ACT_EXIT) begin
         if (found) begin
            rsp_in.status = ST_REMOVED;
            occ_in        = OCC_W'(occ_ff - 1'b1);
         end
      end else if (found) begin
         rsp_in.status    = ST_HIT;
         rsp_in.msg_count = sat_inc(hit_count);
      end else if (full) begin
         rsp_in.status = ST_FULL;
      end else begin
         rsp_in.status    = ST_NEW;
         rsp_in.msg_count = COUNT_W'(1);
         occ_in           = OCC_W'(occ_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= state_ff == S_ACT;
         if (state_ff == S_ACT) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == S_ACT) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `FMCT_ASSERT_NXT(a_act_gives_beat, state_ff == S_ACT, rsp_strobe_ff)
   `FMCT_ASSERT_IMP(a_occ_bound, 1'b1, occ_ff <= OCC_W'(TABLE_DEPTH))
   `FMCT_ASSERT_IMP(a_single_hit, state_ff == S_RED1, $onehot0(hit_vec))
   `FMCT_ASSERT_IMP(a_remove_shrinks, rsp_strobe_ff && (rsp_ff.status == ST_REMOVED),
                    OCC_W'(occ_ff + 1'b1) == $past(occ_ff))
   `FMCT_ASSERT_NXT(a_accept_compares, accept, state_ff == S_CMP)

endmodule

`default_nettype wire
